/* hw/rtl/priority_tx_slot_pool_with_aging_core_macros.svh */
// assertion macros for the slot pool block
// no dependencies
`ifndef PRIORITY_TX_SLOT_POOL_WITH_AGING_CORE_MACROS_SVH
`define PRIORITY_TX_SLOT_POOL_WITH_AGING_CORE_MACROS_SVH
// implication checked every cycle outside reset
`define PTSP_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define PTSP_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* hw/rtl/ptsp_pkg.sv */
// package for the slot pool: function codes, pool codes, queue record
// no dependencies
package ptsp_pkg;
	typedef enum logic [2:0] {
		FN_ALLOC_EXACT = 3'd0,
		FN_ALLOC_FALL  = 3'd1,
		FN_DUP         = 3'd2,
		FN_PICK        = 3'd3,
		FN_TICK        = 3'd4,
		FN_BAD5        = 3'd5,
		FN_BAD6        = 3'd6,
		FN_BAD7        = 3'd7
	} func_t;

	localparam logic [1:0] LVL_HIGH = 2'd0;
	localparam logic [1:0] LVL_NORM = 2'd1;
	localparam logic [1:0] LVL_LOW  = 2'd2;
	localparam int unsigned MAX_RESULTS = 16;

	typedef struct packed {
		func_t       func;
		logic [1:0]  level;
		logic [7:0]  ttl;
		logic [7:0]  backoff;
		logic [15:0] node_index;
		logic        mac_idle;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_DONE
	} bk_state_t;
endpackage

/* hw/rtl/ptsp_front.sv */
// front end: takes commands, casts func to func_t, pushes into a two entry queue
// depends on ptsp_pkg
module ptsp_front import ptsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] func,
	input  logic [1:0] level,
	input  logic [7:0] ttl,
	input  logic [7:0] backoff,
	input  logic [15:0] node_index,
	input  logic       mac_idle,
	input  logic       pop,
	output logic       busy,
	output logic       q_valid,
	output cmd_t       q_head
);
	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{func: func_t'(func), level: level, ttl: ttl,
				backoff: backoff, node_index: node_index, mac_idle: mac_idle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop && q_valid);
		end
	end
endmodule

/* hw/rtl/ptsp_back.sv */
// back end: slot table, one slot per cycle walk for every command
// depends on ptsp_pkg and the macro header
`include "priority_tx_slot_pool_with_aging_core_macros.svh"
module ptsp_back import ptsp_pkg::*; #(
	parameter int HIGH_SLOTS   = 4,
	parameter int NORMAL_SLOTS = 8,
	parameter int LOW_SLOTS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_head,
	output logic        pop,
	output logic        res_valid,
	output logic        found,
	output logic [3:0]  slot,
	output logic [1:0]  level_out,
	output logic [15:0] freed_node,
	output logic        last
);
	localparam int TOTAL = HIGH_SLOTS + NORMAL_SLOTS + LOW_SLOTS;
	localparam int IW    = $clog2(TOTAL);
	localparam int NB    = HIGH_SLOTS;
	localparam int LB    = HIGH_SLOTS + NORMAL_SLOTS;

	logic        valid_q   [TOTAL];
	logic [7:0]  ttl_q     [TOTAL];
	logic [7:0]  bo_q      [TOTAL];
	logic [15:0] node_q    [TOTAL];

	bk_state_t   state_q, state_d;
	cmd_t        cmd_q;
	logic [IW-1:0] idx_q, idx_d;
	logic [4:0]  cnt_q, cnt_d;

	// pending result held one slot behind so that last can be known
	logic        pend_q, pend_d;
	logic [3:0]  pslot_q, pslot_d;
	logic [1:0]  plvl_q, plvl_d;
	logic [15:0] pnode_q, pnode_d;

	logic        o_v_d, o_f_d, o_l_d;
	logic [3:0]  o_s_d;
	logic [1:0]  o_lv_d;
	logic [15:0] o_n_d;

	logic [IW-1:0] cur;
	logic [1:0]    cur_pool;
	logic          in_search, is_tick, hit, do_free, wr_alloc;

	assign cur = idx_q;

	always_comb begin
		if (idx_q < IW'(NB)) cur_pool = LVL_HIGH;
		else if (idx_q < IW'(LB)) cur_pool = LVL_NORM;
		else cur_pool = LVL_LOW;
	end

	// is the current slot inside the pools this command looks at
	always_comb begin
		unique case (cmd_q.func)
			FN_ALLOC_EXACT: in_search = (cmd_q.level != 2'd3) && (cur_pool == cmd_q.level);
			FN_ALLOC_FALL, FN_DUP:
				in_search = (cmd_q.level != 2'd3) && (cur_pool >= cmd_q.level);
			FN_PICK, FN_TICK: in_search = 1'b1;
			default: in_search = 1'b0;
		endcase
	end

	assign is_tick = (cmd_q.func == FN_TICK);

	always_comb begin
		unique case (cmd_q.func)
			FN_ALLOC_EXACT, FN_ALLOC_FALL: hit = in_search && !valid_q[cur];
			FN_DUP: hit = in_search && valid_q[cur] && (node_q[cur] == cmd_q.node_index);
			FN_PICK: hit = valid_q[cur] && (bo_q[cur] == 8'd0) && (ttl_q[cur] != 8'd0);
			default: hit = 1'b0;
		endcase
	end

	assign do_free  = is_tick && valid_q[cur] && (ttl_q[cur] == 8'd0) &&
		((cur_pool == LVL_NORM) || cmd_q.mac_idle);
	assign wr_alloc = (state_q == BK_WALK) && hit &&
		((cmd_q.func == FN_ALLOC_EXACT) || (cmd_q.func == FN_ALLOC_FALL));

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		pend_d  = pend_q;
		pslot_d = pslot_q;
		plvl_d  = plvl_q;
		pnode_d = pnode_q;
		pop     = 1'b0;
		o_v_d   = 1'b0;
		o_f_d   = 1'b0;
		o_l_d   = 1'b0;
		o_s_d   = '0;
		o_lv_d  = '0;
		o_n_d   = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					idx_d   = '0;
					cnt_d   = '0;
					pend_d  = 1'b0;
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (is_tick) begin
					if (do_free) begin
						// once the report limit is reached the held result stays for the end
						if (pend_q && cnt_q < 5'(MAX_RESULTS)) begin
							o_v_d = 1'b1; o_f_d = 1'b1;
							o_s_d = pslot_q; o_lv_d = plvl_q; o_n_d = pnode_q;
						end
						if (cnt_q < 5'(MAX_RESULTS)) begin
							pend_d  = 1'b1;
							pslot_d = 4'(idx_q);
							plvl_d  = cur_pool;
							pnode_d = node_q[cur];
							cnt_d   = cnt_q + 5'd1;
						end
					end
					if (idx_q == IW'(TOTAL - 1)) state_d = BK_DONE;
					else idx_d = idx_q + IW'(1);
				end else if (hit) begin
					o_v_d = 1'b1; o_f_d = 1'b1; o_l_d = 1'b1;
					o_s_d = 4'(idx_q); o_lv_d = cur_pool;
					state_d = BK_IDLE;
				end else if (idx_q == IW'(TOTAL - 1)) begin
					o_v_d = 1'b1; o_l_d = 1'b1;
					state_d = BK_IDLE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			BK_DONE: begin
				o_v_d = 1'b1; o_l_d = 1'b1;
				if (pend_q) begin
					o_f_d = 1'b1; o_s_d = pslot_q; o_lv_d = plvl_q; o_n_d = pnode_q;
				end
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			res_valid <= 1'b0;
			for (int i = 0; i < TOTAL; i++) begin
				valid_q[i] <= 1'b0;
				ttl_q[i]   <= '0;
				bo_q[i]    <= '0;
				node_q[i]  <= '0;
			end
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			cnt_q     <= cnt_d;
			pend_q    <= pend_d;
			res_valid <= o_v_d;
			if (wr_alloc) begin
				valid_q[cur] <= 1'b1;
				ttl_q[cur]   <= cmd_q.ttl;
				bo_q[cur]    <= cmd_q.backoff;
				node_q[cur]  <= cmd_q.node_index;
			end
			if (state_q == BK_WALK && is_tick) begin
				if (valid_q[cur] && ttl_q[cur] != 8'd0) ttl_q[cur] <= ttl_q[cur] - 8'd1;
				if (do_free) begin
					valid_q[cur] <= 1'b0;
					bo_q[cur]    <= 8'd0;
				end else if (bo_q[cur] != 8'd0) begin
					bo_q[cur] <= bo_q[cur] - 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= q_head;
		pslot_q    <= pslot_d;
		plvl_q     <= plvl_d;
		pnode_q    <= pnode_d;
		found      <= o_f_d;
		slot       <= o_s_d;
		level_out  <= o_lv_d;
		freed_node <= o_n_d;
		last       <= o_l_d;
	end

	`PTSP_ASSERT_IMP(a_pop_idle, clk, arst_n, pop, (state_q == BK_IDLE) && q_valid, "pop outside idle")
	`PTSP_ASSERT_NEXT(a_done_last, clk, arst_n, state_q == BK_DONE, res_valid && last, "tick end without last")
	`PTSP_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= 5'(MAX_RESULTS), "free count overflow")
endmodule

/* hw/rtl/priority_tx_slot_pool_with_aging_core.sv */
// top level of the priority transmit slot pool with aging
// depends on ptsp_pkg, ptsp_front, ptsp_back
//
// usage
// - command channel: start with func, level, ttl, backoff, node_index,
//   mac_idle; an item is taken at a clock edge with start high and busy low
// - result channel: valid strobes for one cycle with found, slot, level_out,
//   freed_node and last; the receiver cannot hold results off
// - a two entry queue sits between the command front and the table walker,
//   so up to two items can wait while the walker is working
// - the walker visits one slot per cycle: allocate, duplicate check and
//   pick ready stop at the first hit, so each item gives a single result
// - tick always walks all TOTAL slots, ages each one and emits one result
//   per freed slot up to MAX_RESULTS (the last one marked), or one empty
//   result; the walker takes no new item until the walk is done
// - results are registered and reach the ports in the cycle after the walker decides them
// - reset clears the whole table, the queue and the walker at once
// - unknown func, or level 3 with allocate or duplicate check, gives one result with found low
module priority_tx_slot_pool_with_aging_core import ptsp_pkg::*; #(
	parameter int HIGH_SLOTS   = 4,
	parameter int NORMAL_SLOTS = 8,
	parameter int LOW_SLOTS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [1:0]  level,
	input  logic [7:0]  ttl,
	input  logic [7:0]  backoff,
	input  logic [15:0] node_index,
	input  logic        mac_idle,
	output logic        valid,
	output logic        found,
	output logic [3:0]  slot,
	output logic [1:0]  level_out,
	output logic [15:0] freed_node,
	output logic        last
);
	logic q_valid, pop;
	cmd_t q_head;

	// front: accept and queue items
	ptsp_front u_front (
		.clk, .arst_n, .start, .func, .level, .ttl, .backoff, .node_index,
		.mac_idle, .pop, .busy, .q_valid, .q_head
	);

	// back: walk the slot table
	ptsp_back #(
		.HIGH_SLOTS(HIGH_SLOTS), .NORMAL_SLOTS(NORMAL_SLOTS), .LOW_SLOTS(LOW_SLOTS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_head, .pop,
		.res_valid(valid), .found, .slot, .level_out, .freed_node, .last
	);
endmodule
